/* rtl/core/jsu_pkg.sv */
// jsu_pkg: shared types and constants for the JSON string unescape block.
// Used by jsu_front, jsu_queue, jsu_back and json_string_unescape_utf8.
// No dependencies.
package jsu_pkg;

    // Most results a single input transaction can produce (one 4-byte UTF-8 char)
    localparam int MaxRes       = 4;
    localparam int ResIdxW      = $clog2(MaxRes);
    localparam int QueueDepthDefault = 4;

    // Input transaction kinds
    localparam logic [1:0] KIND_BEGIN = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    typedef enum logic [3:0] {
        ERR_NONE          = 4'd0,
        ERR_UNTERM_STRING = 4'd1,
        ERR_UNTERM_ESCAPE = 4'd2,
        ERR_CONTROL_CHAR  = 4'd3,
        ERR_BAD_ESCAPE    = 4'd4,
        ERR_SHORT_HEX     = 4'd5,
        ERR_BAD_HEX       = 4'd6,
        ERR_LONE_SURR     = 4'd7,
        ERR_INVALID_UTF8  = 4'd8,
        ERR_TRUNC_UTF8    = 4'd9
    } err_t;

    // One group of results caused by one input transaction.
    // data[0] goes out first; last_idx is the index of the final result.
    typedef struct packed {
        logic [MaxRes-1:0][7:0] data;
        logic [ResIdxW-1:0]     last_idx;
        logic                   byte_valid;
        logic                   done;
        err_t                   err;
    } grp_t;

endpackage

/* rtl/core/json_string_unescape_utf8.sv */
// JSON string body decoder with UTF-8 validation. After a begin transaction
// (sent once the opening quote is seen) each data byte is decoded: simple
// escapes, \uXXXX escapes and surrogate pairs come out as UTF-8 bytes, raw
// multibyte UTF-8 is checked (bad lead or continuation bytes, overlong forms,
// surrogates, values above U+10FFFF) and passed through, control bytes are
// rejected and the closing quote gives a done result. The first error gives
// one result carrying its code, then input is ignored until the next begin.
// Input rate: one transaction per cycle while in_ready is high; the decoder
// state machine settles each byte in the cycle it is accepted. Output rate:
// one result per cycle while out_ready is high. An input that yields N results
// (N up to 4, e.g. a 4-byte character) sends them out one after another; a
// queue of QueueDepth result groups between decoder and output stage absorbs
// these bursts, and in_ready drops only when that queue is full. With an empty
// queue the group is written into the queue when the input is accepted, and
// its first result is then loaded into the registered output stage.
// Depends on jsu_pkg, jsu_front, jsu_queue, jsu_back.
module json_string_unescape_utf8 #(
    parameter int QueueDepth = jsu_pkg::QueueDepthDefault
) (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [7:0] data_byte,
    // result channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       last,
    output logic       done_res,
    output logic [3:0] error_code
);
    import jsu_pkg::*;

    logic accept;
    logic push, pop, empty, full;
    grp_t push_grp, head_grp;

    // Ready only depends on queue space, never on decoder state.
    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    // Front: decode state machine, one group per productive transaction
    jsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (kind),
        .data_byte (data_byte),
        .push      (push),
        .push_grp  (push_grp)
    );

    // Group queue decoupling decode from serialization
    jsu_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_grp (push_grp),
        .pop      (pop),
        .head_grp (head_grp),
        .empty    (empty),
        .full     (full)
    );

    // Back: serializes groups into the registered result channel
    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_grp   (head_grp),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .last       (last),
        .done_res   (done_res),
        .error_code (error_code)
    );

endmodule

/* rtl/core/jsu_front.sv */
// jsu_front: accepts input transactions, runs the string/escape/UTF-8
// decode state machine and pushes one result group per productive input.
// Depends on jsu_pkg.
module jsu_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [1:0]         kind,
    input  logic [7:0]         data_byte,
    output logic               push,
    output jsu_pkg::grp_t      push_grp
);
    import jsu_pkg::*;

    typedef enum logic [11:0] {
        MODE_IDLE = 12'b0000_0000_0001,
        MODE_STR  = 12'b0000_0000_0010,
        MODE_ESC  = 12'b0000_0000_0100,
        MODE_HEX1 = 12'b0000_0000_1000,
        MODE_SBS  = 12'b0000_0001_0000,
        MODE_SU   = 12'b0000_0010_0000,
        MODE_HEX2 = 12'b0000_0100_0000,
        MODE_UTF2 = 12'b0000_1000_0000,
        MODE_UTF3 = 12'b0001_0000_0000,
        MODE_UTF4 = 12'b0010_0000_0000,
        MODE_DONE = 12'b0100_0000_0000,
        MODE_ERR  = 12'b1000_0000_0000
    } mode_t;

    mode_t        mode_reg, mode_next;
    logic [15:0]  hex_value_reg, hex_value_next;
    logic [1:0]   hex_count_reg, hex_count_next;
    logic [9:0]   high_surr_reg, high_surr_next;
    logic [20:0]  code_point_reg, code_point_next;
    logic [1:0]   bytes_needed_reg, bytes_needed_next;
    logic [23:0]  held_bytes_reg, held_bytes_next;

    // 16 when not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h37);
        return d;
    endfunction

    function automatic grp_t encode_cp(input logic [20:0] cp);
        grp_t g;
        g = '0;
        g.byte_valid = 1'b1;
        g.err = ERR_NONE;
        if (cp < 21'h80) begin
            g.data[0]  = {1'b0, cp[6:0]};
            g.last_idx = ResIdxW'(0);
        end else if (cp < 21'h800) begin
            g.data[0]  = {3'b110, cp[10:6]};
            g.data[1]  = {2'b10, cp[5:0]};
            g.last_idx = ResIdxW'(1);
        end else if (cp < 21'h10000) begin
            g.data[0]  = {4'b1110, cp[15:12]};
            g.data[1]  = {2'b10, cp[11:6]};
            g.data[2]  = {2'b10, cp[5:0]};
            g.last_idx = ResIdxW'(2);
        end else begin
            g.data[0]  = {5'b11110, cp[20:18]};
            g.data[1]  = {2'b10, cp[17:12]};
            g.data[2]  = {2'b10, cp[11:6]};
            g.data[3]  = {2'b10, cp[5:0]};
            g.last_idx = ResIdxW'(3);
        end
        return g;
    endfunction

    logic [4:0]  hex_d;
    logic [15:0] hex_v;
    logic [20:0] cp_acc;
    logic [20:0] surr_cp;
    logic [20:0] min_cp;

    assign hex_d   = hex_digit(data_byte);
    assign hex_v   = {hex_value_reg[11:0], hex_d[3:0]};
    assign cp_acc  = {code_point_reg[14:0], data_byte[5:0]};
    assign surr_cp = 21'h10000 + {1'b0, high_surr_reg, hex_v[9:0]};

    always_comb
    begin
        mode_next         = mode_reg;
        hex_value_next    = hex_value_reg;
        hex_count_next    = hex_count_reg;
        high_surr_next    = high_surr_reg;
        code_point_next   = code_point_reg;
        bytes_needed_next = bytes_needed_reg;
        held_bytes_next   = held_bytes_reg;
        push              = 1'b0;
        push_grp          = '0;
        push_grp.err      = ERR_NONE;
        min_cp            = 21'h10000;

        if (accept) begin
            case (kind)
                KIND_BEGIN:
                begin
                    mode_next         = MODE_STR;
                    hex_value_next    = '0;
                    hex_count_next    = '0;
                    high_surr_next    = '0;
                    code_point_next   = '0;
                    bytes_needed_next = '0;
                    held_bytes_next   = '0;
                end
                KIND_END:
                begin
                    push = 1'b1;
                    mode_next = MODE_ERR;
                    case (mode_reg)
                        MODE_STR:  push_grp.err = ERR_UNTERM_STRING;
                        MODE_ESC:  push_grp.err = ERR_UNTERM_ESCAPE;
                        MODE_HEX1,
                        MODE_HEX2: push_grp.err = ERR_SHORT_HEX;
                        MODE_SBS,
                        MODE_SU:   push_grp.err = ERR_LONE_SURR;
                        MODE_UTF2,
                        MODE_UTF3,
                        MODE_UTF4: push_grp.err = ERR_TRUNC_UTF8;
                        default:
                        begin
                            push      = 1'b0;
                            mode_next = mode_reg;
                        end
                    endcase
                end
                KIND_DATA:
                begin
                    case (mode_reg)
                        MODE_STR:
                        begin
                            if (data_byte == 8'h22) begin
                                mode_next     = MODE_DONE;
                                push          = 1'b1;
                                push_grp.done = 1'b1;
                            end else if (data_byte < 8'h20) begin
                                mode_next    = MODE_ERR;
                                push         = 1'b1;
                                push_grp.err = ERR_CONTROL_CHAR;
                            end else if (data_byte == 8'h5C) begin
                                mode_next = MODE_ESC;
                            end else if (data_byte < 8'h80) begin
                                push                = 1'b1;
                                push_grp.byte_valid = 1'b1;
                                push_grp.data[0]    = data_byte;
                            end else begin
                                held_bytes_next = {16'h0, data_byte};
                                if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
                                    mode_next         = MODE_UTF2;
                                    bytes_needed_next = 2'd1;
                                    code_point_next   = {16'h0, data_byte[4:0]};
                                end else if (data_byte >= 8'hE0 && data_byte <= 8'hEF) begin
                                    mode_next         = MODE_UTF3;
                                    bytes_needed_next = 2'd2;
                                    code_point_next   = {17'h0, data_byte[3:0]};
                                end else if (data_byte >= 8'hF0 && data_byte <= 8'hF4) begin
                                    mode_next         = MODE_UTF4;
                                    bytes_needed_next = 2'd3;
                                    code_point_next   = {18'h0, data_byte[2:0]};
                                end else begin
                                    mode_next    = MODE_ERR;
                                    push         = 1'b1;
                                    push_grp.err = ERR_INVALID_UTF8;
                                end
                            end
                        end
                        MODE_ESC:
                        begin
                            mode_next           = MODE_STR;
                            push                = 1'b1;
                            push_grp.byte_valid = 1'b1;
                            case (data_byte)
                                8'h22:   push_grp.data[0] = 8'h22;
                                8'h5C:   push_grp.data[0] = 8'h5C;
                                8'h2F:   push_grp.data[0] = 8'h2F;
                                8'h62:   push_grp.data[0] = 8'h08;
                                8'h66:   push_grp.data[0] = 8'h0C;
                                8'h6E:   push_grp.data[0] = 8'h0A;
                                8'h72:   push_grp.data[0] = 8'h0D;
                                8'h74:   push_grp.data[0] = 8'h09;
                                8'h75:
                                begin
                                    push           = 1'b0;
                                    mode_next      = MODE_HEX1;
                                    hex_value_next = '0;
                                    hex_count_next = '0;
                                end
                                default:
                                begin
                                    push                = 1'b1;
                                    push_grp.byte_valid = 1'b0;
                                    mode_next           = MODE_ERR;
                                    push_grp.err        = ERR_BAD_ESCAPE;
                                end
                            endcase
                        end
                        MODE_HEX1,
                        MODE_HEX2:
                        begin
                            if (hex_d[4]) begin
                                mode_next    = MODE_ERR;
                                push         = 1'b1;
                                push_grp.err = ERR_BAD_HEX;
                            end else if (hex_count_reg != 2'd3) begin
                                hex_value_next = hex_v;
                                hex_count_next = hex_count_reg + 2'd1;
                            end else begin
                                hex_value_next = '0;
                                hex_count_next = '0;
                                if (mode_reg == MODE_HEX1) begin
                                    if (hex_v >= 16'hD800 && hex_v <= 16'hDBFF) begin
                                        high_surr_next = hex_v[9:0];
                                        mode_next      = MODE_SBS;
                                    end else if (hex_v >= 16'hDC00 && hex_v <= 16'hDFFF) begin
                                        mode_next    = MODE_ERR;
                                        push         = 1'b1;
                                        push_grp.err = ERR_LONE_SURR;
                                    end else begin
                                        mode_next = MODE_STR;
                                        push      = 1'b1;
                                        push_grp  = encode_cp({5'h0, hex_v});
                                    end
                                end else begin
                                    if (hex_v < 16'hDC00 || hex_v > 16'hDFFF) begin
                                        mode_next    = MODE_ERR;
                                        push         = 1'b1;
                                        push_grp.err = ERR_LONE_SURR;
                                    end else begin
                                        mode_next = MODE_STR;
                                        push      = 1'b1;
                                        push_grp  = encode_cp(surr_cp);
                                    end
                                end
                            end
                        end
                        MODE_SBS:
                        begin
                            if (data_byte == 8'h5C) begin
                                mode_next = MODE_SU;
                            end else begin
                                mode_next    = MODE_ERR;
                                push         = 1'b1;
                                push_grp.err = ERR_LONE_SURR;
                            end
                        end
                        MODE_SU:
                        begin
                            if (data_byte == 8'h75) begin
                                mode_next      = MODE_HEX2;
                                hex_value_next = '0;
                                hex_count_next = '0;
                            end else begin
                                mode_next    = MODE_ERR;
                                push         = 1'b1;
                                push_grp.err = ERR_LONE_SURR;
                            end
                        end
                        MODE_UTF2,
                        MODE_UTF3,
                        MODE_UTF4:
                        begin
                            if (data_byte[7:6] != 2'b10) begin
                                mode_next    = MODE_ERR;
                                push         = 1'b1;
                                push_grp.err = ERR_INVALID_UTF8;
                            end else begin
                                code_point_next = cp_acc;
                                if (bytes_needed_reg > 2'd1) begin
                                    held_bytes_next   = {held_bytes_reg[15:0], data_byte};
                                    bytes_needed_next = bytes_needed_reg - 2'd1;
                                end else begin
                                    if (mode_reg == MODE_UTF2)
                                        min_cp = 21'h80;
                                    else if (mode_reg == MODE_UTF3)
                                        min_cp = 21'h800;
                                    if (cp_acc < min_cp || cp_acc > 21'h10FFFF ||
                                        (cp_acc >= 21'hD800 && cp_acc <= 21'hDFFF)) begin
                                        mode_next    = MODE_ERR;
                                        push         = 1'b1;
                                        push_grp.err = ERR_INVALID_UTF8;
                                    end else begin
                                        push                = 1'b1;
                                        push_grp.byte_valid = 1'b1;
                                        if (mode_reg == MODE_UTF2) begin
                                            push_grp.data[0]  = held_bytes_reg[7:0];
                                            push_grp.data[1]  = data_byte;
                                            push_grp.last_idx = ResIdxW'(1);
                                        end else if (mode_reg == MODE_UTF3) begin
                                            push_grp.data[0]  = held_bytes_reg[15:8];
                                            push_grp.data[1]  = held_bytes_reg[7:0];
                                            push_grp.data[2]  = data_byte;
                                            push_grp.last_idx = ResIdxW'(2);
                                        end else begin
                                            push_grp.data[0]  = held_bytes_reg[23:16];
                                            push_grp.data[1]  = held_bytes_reg[15:8];
                                            push_grp.data[2]  = held_bytes_reg[7:0];
                                            push_grp.data[3]  = data_byte;
                                            push_grp.last_idx = ResIdxW'(3);
                                        end
                                        mode_next         = MODE_STR;
                                        bytes_needed_next = '0;
                                        held_bytes_next   = '0;
                                        code_point_next   = '0;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg         <= MODE_IDLE;
            hex_value_reg    <= '0;
            hex_count_reg    <= '0;
            high_surr_reg    <= '0;
            code_point_reg   <= '0;
            bytes_needed_reg <= '0;
            held_bytes_reg   <= '0;
        end else begin
            mode_reg         <= mode_next;
            hex_value_reg    <= hex_value_next;
            hex_count_reg    <= hex_count_next;
            high_surr_reg    <= high_surr_next;
            code_point_reg   <= code_point_next;
            bytes_needed_reg <= bytes_needed_next;
            held_bytes_reg   <= held_bytes_next;
        end
    end

endmodule

/* rtl/core/jsu_queue.sv */
// jsu_queue: small FIFO of result groups between front and back.
// Depends on jsu_pkg.
module jsu_queue #(
    parameter int Depth = jsu_pkg::QueueDepthDefault
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jsu_pkg::grp_t push_grp,
    input  logic          pop,
    output jsu_pkg::grp_t head_grp,
    output logic          empty,
    output logic          full
);
    import jsu_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    grp_t            entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CntW'(Depth));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_grp = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CntW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CntW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/jsu_back.sv */
// jsu_back: walks the head result group one result per cycle, while the output
// is not stalled, into the output register. Depends on jsu_pkg.
module jsu_back (
    input  logic          clk,
    input  logic          rst_n,
    input  jsu_pkg::grp_t head_grp,
    input  logic          empty,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          byte_valid,
    output logic          last,
    output logic          done_res,
    output logic [3:0]    error_code
);
    import jsu_pkg::*;

    logic               out_valid_reg, out_valid_next;
    logic [ResIdxW-1:0] idx_reg, idx_next;
    logic [7:0]         out_byte_reg;
    logic               byte_valid_reg;
    logic               last_reg;
    logic               done_reg;
    err_t               err_reg;
    logic               load, take, is_last;

    assign load    = !out_valid_reg || out_ready;
    assign take    = load && !empty;
    assign is_last = (idx_reg == head_grp.last_idx);
    assign pop     = take && is_last;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        if (load)
            out_valid_next = !empty;
        if (take)
            idx_next = is_last ? '0 : idx_reg + ResIdxW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            out_byte_reg   <= head_grp.data[idx_reg];
            byte_valid_reg <= head_grp.byte_valid;
            last_reg       <= is_last;
            done_reg       <= head_grp.done;
            err_reg        <= head_grp.err;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign last       = last_reg;
    assign done_res   = done_reg;
    assign error_code = err_reg;

endmodule

/* tb/sv/tb.sv */
// tb: self-checking testbench for json_string_unescape_utf8.
// Sends begin/data/end transactions, predicts the decoded UTF-8 stream in-line
// and checks every result transaction. Depends on jsu_pkg and the RTL top.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    // Generous bound: a few hundred transactions, up to four results each,
    // random stalls on both sides and one long output hold-off.
    localparam int CycleLimit = 300000;
    localparam int SettleCycles = 20;

    // kind 3 is not a defined transaction; the block must ignore it
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    // Decoder modes of the in-line prediction
    typedef enum int {
        DM_IDLE, DM_STR, DM_ESC, DM_HEX1, DM_SBS, DM_SU, DM_HEX2,
        DM_UTF2, DM_UTF3, DM_UTF4, DM_DONE, DM_ERR
    } dec_mode_e;

    // One expected result transaction
    typedef struct packed {
        logic [7:0] ch;
        logic       ch_valid;
        logic       is_last;
        logic       closed;
        err_t       err;
    } dec_result_t;

    typedef logic [3:0][7:0] quad_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] kind = KIND_BEGIN;
    logic [7:0] data_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       done_res;
    logic [3:0] error_code;

    // Predicted decoder state
    dec_mode_e   dmode = DM_IDLE;
    logic [15:0] hex_acc = '0;
    int unsigned hex_n = 0;
    logic [9:0]  hi_half = '0;
    logic [20:0] cp_acc = '0;
    int unsigned utf_left = 0;
    logic [23:0] lead_bytes = '0;

    dec_result_t decoded_q[$];   // expected results, oldest first
    dec_result_t step_res[$];    // results of the transaction being predicted

    int fail_count = 0;
    int live_items = 0;          // transactions the decoder actually acts on
    int cycles = 0;

    // Idle controls shared by the sender, the receiver process and the tests
    bit tx_gaps = 1'b1;
    bit rx_steady = 1'b0;
    int rx_hold_req = 0;
    int rx_hold_left = 0;

    json_string_unescape_utf8 dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .last       (last),
        .done_res   (done_res),
        .error_code (error_code)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void push_res(logic [7:0] ch, bit v, bit closed, err_t e);
        dec_result_t r;
        r.ch = ch;
        r.ch_valid = v;
        r.is_last = 1'b0;
        r.closed = closed;
        r.err = e;
        step_res.insert(step_res.size(), r);
    endfunction

    // First error ends the string; everything after it is dropped until begin
    function automatic void raise_error(err_t e);
        dmode = DM_ERR;
        push_res(8'h00, 1'b0, 1'b0, e);
    endfunction

    // UTF-8 encoding of a scalar value, first byte in q[0]; returns the length.
    // Also used by the stimulus to build raw multibyte characters.
    function automatic int utf8_encode(logic [20:0] cp, output quad_t q);
        q = '0;
        if (cp < 21'h80) begin
            q[0] = cp[7:0];
            return 1;
        end
        if (cp < 21'h800) begin
            q[0] = {3'b110, cp[10:6]};
            q[1] = {2'b10, cp[5:0]};
            return 2;
        end
        if (cp < 21'h10000) begin
            q[0] = {4'b1110, cp[15:12]};
            q[1] = {2'b10, cp[11:6]};
            q[2] = {2'b10, cp[5:0]};
            return 3;
        end
        q[0] = {5'b11110, cp[20:18]};
        q[1] = {2'b10, cp[17:12]};
        q[2] = {2'b10, cp[11:6]};
        q[3] = {2'b10, cp[5:0]};
        return 4;
    endfunction

    function automatic void push_code_point(logic [20:0] cp);
        quad_t q;
        int n;
        n = utf8_encode(cp, q);
        for (int k = 0; k < n; k++)
            push_res(q[k], 1'b1, 1'b0, ERR_NONE);
    endfunction

    // 0..15 for a hex digit of either case, 16 otherwise
    function automatic int hex_nibble(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return 16;
    endfunction

    function automatic void decode_string_byte(logic [7:0] c);
        if (c == CH_QUOTE) begin
            dmode = DM_DONE;
            push_res(8'h00, 1'b0, 1'b1, ERR_NONE);
        end else if (c < 8'h20) begin
            raise_error(ERR_CONTROL_CHAR);
        end else if (c == CH_BSLASH) begin
            dmode = DM_ESC;
        end else if (c < 8'h80) begin
            push_res(c, 1'b1, 1'b0, ERR_NONE);
        end else begin
            lead_bytes = {16'h0, c};
            if (c >= 8'hC2 && c <= 8'hDF) begin
                dmode = DM_UTF2;
                utf_left = 1;
                cp_acc = {16'h0, c[4:0]};
            end else if (c >= 8'hE0 && c <= 8'hEF) begin
                dmode = DM_UTF3;
                utf_left = 2;
                cp_acc = {17'h0, c[3:0]};
            end else if (c >= 8'hF0 && c <= 8'hF4) begin
                dmode = DM_UTF4;
                utf_left = 3;
                cp_acc = {18'h0, c[2:0]};
            end else begin
                raise_error(ERR_INVALID_UTF8);
            end
        end
    endfunction

    function automatic void decode_escape_byte(logic [7:0] c);
        logic [7:0] b;
        bit emits;
        b = c;
        emits = 1'b1;
        dmode = DM_STR;
        case (c)
            8'h22, 8'h5C, 8'h2F: b = c;
            8'h62: b = 8'h08;   // \b
            8'h66: b = 8'h0C;   // \f
            8'h6E: b = 8'h0A;   // \n
            8'h72: b = 8'h0D;   // \r
            8'h74: b = 8'h09;   // \t
            CH_U: begin
                dmode = DM_HEX1;
                hex_acc = '0;
                hex_n = 0;
                emits = 1'b0;
            end
            default: begin
                raise_error(ERR_BAD_ESCAPE);
                emits = 1'b0;
            end
        endcase
        if (emits)
            push_res(b, 1'b1, 1'b0, ERR_NONE);
    endfunction

    function automatic void decode_hex_byte(logic [7:0] c);
        int d;
        logic [15:0] v;
        d = hex_nibble(c);
        if (d > 15) begin
            raise_error(ERR_BAD_HEX);
            return;
        end
        v = {hex_acc[11:0], 4'(d)};
        if (hex_n < 3) begin
            hex_acc = v;
            hex_n++;
            return;
        end
        hex_acc = '0;
        hex_n = 0;
        if (dmode == DM_HEX1) begin
            if (v >= 16'hD800 && v <= 16'hDBFF) begin
                hi_half = v[9:0];
                dmode = DM_SBS;
            end else if (v >= 16'hDC00 && v <= 16'hDFFF) begin
                raise_error(ERR_LONE_SURR);
            end else begin
                dmode = DM_STR;
                push_code_point({5'd0, v});
            end
        end else if (v < 16'hDC00 || v > 16'hDFFF) begin
            raise_error(ERR_LONE_SURR);
        end else begin
            dmode = DM_STR;
            push_code_point(21'h10000 + {1'b0, hi_half, v[9:0]});
        end
    endfunction

    // Continuation bytes are held until the sequence is known to be valid
    function automatic void decode_utf_byte(logic [7:0] c);
        int seq_len;
        logic [20:0] min_cp;
        logic [23:0] sh;
        if (c[7:6] != 2'b10) begin
            raise_error(ERR_INVALID_UTF8);
            return;
        end
        cp_acc = {cp_acc[14:0], c[5:0]};
        if (utf_left > 1) begin
            lead_bytes = {lead_bytes[15:0], c};
            utf_left--;
            return;
        end
        seq_len = (dmode == DM_UTF2) ? 2 : (dmode == DM_UTF3) ? 3 : 4;
        min_cp = (seq_len == 2) ? 21'h80 : (seq_len == 3) ? 21'h800 : 21'h10000;
        if (cp_acc < min_cp || cp_acc > 21'h10FFFF ||
            (cp_acc >= 21'hD800 && cp_acc <= 21'hDFFF)) begin
            raise_error(ERR_INVALID_UTF8);
            return;
        end
        for (int k = 0; k < seq_len - 1; k++) begin
            sh = lead_bytes >> (8 * (seq_len - 2 - k));
            push_res(sh[7:0], 1'b1, 1'b0, ERR_NONE);
        end
        push_res(c, 1'b1, 1'b0, ERR_NONE);
        dmode = DM_STR;
        utf_left = 0;
        lead_bytes = '0;
        cp_acc = '0;
    endfunction

    // Advance the prediction by one input transaction and queue its results
    function automatic void unescape_step(logic [1:0] k, logic [7:0] c);
        step_res.delete();
        case (k)
            KIND_BEGIN: begin
                hex_acc = '0;
                hex_n = 0;
                hi_half = '0;
                cp_acc = '0;
                utf_left = 0;
                lead_bytes = '0;
                dmode = DM_STR;
            end
            KIND_END: begin
                case (dmode)
                    DM_STR:                   raise_error(ERR_UNTERM_STRING);
                    DM_ESC:                   raise_error(ERR_UNTERM_ESCAPE);
                    DM_HEX1, DM_HEX2:         raise_error(ERR_SHORT_HEX);
                    DM_SBS, DM_SU:            raise_error(ERR_LONE_SURR);
                    DM_UTF2, DM_UTF3, DM_UTF4: raise_error(ERR_TRUNC_UTF8);
                    default: ;
                endcase
            end
            KIND_DATA: begin
                case (dmode)
                    DM_STR:           decode_string_byte(c);
                    DM_ESC:           decode_escape_byte(c);
                    DM_HEX1, DM_HEX2: decode_hex_byte(c);
                    DM_SBS: begin
                        // a high surrogate must be followed at once by \u
                        if (c == CH_BSLASH)
                            dmode = DM_SU;
                        else
                            raise_error(ERR_LONE_SURR);
                    end
                    DM_SU: begin
                        if (c == CH_U) begin
                            dmode = DM_HEX2;
                            hex_acc = '0;
                            hex_n = 0;
                        end else begin
                            raise_error(ERR_LONE_SURR);
                        end
                    end
                    DM_UTF2, DM_UTF3, DM_UTF4: decode_utf_byte(c);
                    default: ;
                endcase
            end
            default: ;
        endcase
        foreach (step_res[i]) begin
            dec_result_t r;
            r = step_res[i];
            r.is_last = (i == step_res.size() - 1);
            decoded_q.insert(decoded_q.size(), r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: receiver stalls, result checking, cycle bound
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Receiver: random stalls, a no-stall mode, and a long hold-off counted here
    always @(posedge clk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end else if (rx_steady) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= 33);
        end
    end

    // Each result transaction is compared with the oldest expectation
    always @(posedge clk) begin : check_results
        dec_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (decoded_q.size() == 0) begin
                report_mismatch("result with nothing pending, out_byte", out_byte, 0);
            end else begin
                want = decoded_q.pop_front();
                if (out_byte !== want.ch)
                    report_mismatch("out_byte", out_byte, want.ch);
                if (byte_valid !== want.ch_valid)
                    report_mismatch("byte_valid", byte_valid, want.ch_valid);
                if (last !== want.is_last)
                    report_mismatch("last", last, want.is_last);
                if (done_res !== want.closed)
                    report_mismatch("done_res", done_res, want.closed);
                if (error_code !== want.err)
                    report_mismatch("error_code", error_code, want.err);
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("TIMEOUT after %0d cycles, %0d results pending", cycles, decoded_q.size());
            $display("json_string_unescape_utf8 regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one transaction and return at the edge where it is accepted.
    // in_valid stays high afterwards so back-to-back transactions need no
    // second assignment in the same step; callers that wait lower it first.
    task automatic send_json_item(logic [1:0] k, logic [7:0] c);
        if (tx_gaps) begin
            while ($urandom_range(99) < 33) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        kind <= k;
        data_byte <= c;
        if (k == KIND_BEGIN ||
            (k != KIND_UNUSED && !(dmode inside {DM_IDLE, DM_DONE, DM_ERR})))
            live_items++;
        // prediction only depends on earlier transactions, all accepted
        unescape_step(k, c);
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_data(logic [7:0] c);
        send_json_item(KIND_DATA, c);
    endtask

    task automatic send_end();
        send_json_item(KIND_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_begin();
        send_json_item(KIND_BEGIN, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_data(s[i]);
    endtask

    // Stop offering and wait until every predicted result has come out
    task automatic wait_all_decoded();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (decoded_q.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 10)
            return 8'h30 + {4'd0, n};
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, n} - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (hex_nibble(c) <= 15);
        return c;
    endfunction

    // Leading cnt hex digits of v
    task automatic send_hex_digits(logic [15:0] v, int cnt);
        for (int i = 0; i < cnt; i++)
            send_data(hex_char(v[15 - 4 * i -: 4]));
    endtask

    task automatic send_u_escape(logic [15:0] v);
        send_text("\\u");
        send_hex_digits(v, 4);
    endtask

    task automatic send_high_surrogate();
        send_u_escape(16'(16'hD800 + $urandom_range(0, 16'h3FF)));
    endtask

    // Random scalar value of two, three or four UTF-8 bytes, boundaries now and then
    function automatic logic [20:0] multibyte_cp();
        logic [20:0] edges [8] = '{21'h80, 21'h7FF, 21'h800, 21'hD7FF,
                                   21'hE000, 21'hFFFF, 21'h10000, 21'h10FFFF};
        logic [20:0] cp;
        if ($urandom_range(0, 7) == 0)
            return edges[$urandom_range(0, 7)];
        case ($urandom_range(0, 2))
            0: cp = 21'($urandom_range(21'h80, 21'h7FF));
            1: cp = 21'($urandom_range(21'h800, 21'hFFFF));
            default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
        endcase
        // move surrogates up out of the surrogate range, to U+F800..U+FFFF
        if (cp >= 21'hD800 && cp <= 21'hDFFF)
            cp ^= 21'h2000;
        return cp;
    endfunction

    task automatic send_raw_cp(logic [20:0] cp);
        quad_t q;
        int n;
        n = utf8_encode(cp, q);
        for (int k = 0; k < n; k++)
            send_data(q[k]);
    endtask

    function automatic logic [7:0] printable_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(8'h20, 8'h7E));
        while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    // One well-formed piece of string content
    task automatic send_random_token();
        logic [7:0] escapes [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};
        logic [15:0] v;
        case ($urandom_range(0, 9))
            3: begin
                send_data(CH_BSLASH);
                send_data(escapes[$urandom_range(0, 7)]);
            end
            4: begin
                case ($urandom_range(0, 2))
                    0: v = 16'($urandom_range(0, 16'h7F));
                    1: v = 16'($urandom_range(16'h80, 16'h7FF));
                    default: v = 16'($urandom_range(16'h800, 16'hFFFF));
                endcase
                if (v >= 16'hD800 && v <= 16'hDFFF)
                    v ^= 16'h2000;
                send_u_escape(v);
            end
            5: begin
                send_high_surrogate();
                send_u_escape(16'(16'hDC00 + $urandom_range(0, 16'h3FF)));
            end
            6, 7: send_raw_cp(multibyte_cp());
            9: begin
                // a fresh begin in mid-string discards everything open
                if ($urandom_range(0, 3) == 0)
                    send_begin();
                else
                    send_data(printable_byte());
            end
            default: send_data(printable_byte());
        endcase
    endtask

    // String endings that hit every error path other than the unterminated string
    task automatic send_broken_tail(int which);
        logic [7:0] c;
        logic [15:0] v;
        quad_t q;
        int n;
        int m;
        case (which)
            0: send_data(8'($urandom_range(0, 8'h1F)));         // control byte
            1: begin                                             // unknown escape
                do
                    c = 8'($urandom_range(0, 255));
                while (c inside {8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72,
                                 8'h74, CH_U});
                send_data(CH_BSLASH);
                send_data(c);
            end
            2: begin                                             // bad hex digit
                send_text("\\u");
                send_hex_digits(16'($urandom), $urandom_range(0, 3));
                send_data(non_hex_byte());
            end
            3: begin                                             // end inside hex
                send_text("\\u");
                send_hex_digits(16'($urandom), $urandom_range(0, 3));
                send_end();
            end
            4: begin                                             // end after backslash
                send_data(CH_BSLASH);
                send_end();
            end
            5: send_u_escape(16'(16'hDC00 + $urandom_range(0, 16'h3FF))); // lone low half
            6: begin                                             // high half, no backslash
                send_high_surrogate();
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CH_BSLASH);
                send_data(c);
            end
            7: begin                                             // high half, backslash, no u
                send_high_surrogate();
                send_data(CH_BSLASH);
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CH_U);
                send_data(c);
            end
            8: begin                                             // second value not low half
                send_high_surrogate();
                v = 16'($urandom);
                if (v[15:10] == 6'b110111)
                    v[15] = 1'b0;
                send_u_escape(v);
            end
            9: begin
                send_high_surrogate();
                send_end();
            end
            10: begin
                send_high_surrogate();
                send_data(CH_BSLASH);
                send_end();
            end
            11: begin                                            // short hex in second half
                send_high_surrogate();
                send_text("\\u");
                send_hex_digits(16'(16'hDC00 + $urandom_range(0, 16'h3FF)),
                                $urandom_range(0, 3));
                send_end();
            end
            12: begin                                            // bad lead byte
                if ($urandom_range(0, 1))
                    send_data(8'($urandom_range(8'h80, 8'hC1)));
                else
                    send_data(8'($urandom_range(8'hF5, 8'hFF)));
            end
            13, 17: begin                                        // broken or cut sequence
                n = utf8_encode(multibyte_cp(), q);
                m = $urandom_range(1, n - 1);
                for (int k = 0; k < m; k++)
                    send_data(q[k]);
                if (which == 17) begin
                    send_end();
                end else begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c[7:6] == 2'b10);
                    send_data(c);
                end
            end
            14: begin                                            // overlong forms
                if ($urandom_range(0, 1)) begin
                    send_data(8'hE0);
                    send_data(8'($urandom_range(8'h80, 8'h9F)));
                    send_data(8'($urandom_range(8'h80, 8'hBF)));
                end else begin
                    send_data(8'hF0);
                    send_data(8'($urandom_range(8'h80, 8'h8F)));
                    send_data(8'($urandom_range(8'h80, 8'hBF)));
                    send_data(8'($urandom_range(8'h80, 8'hBF)));
                end
            end
            15: begin                                            // encoded surrogate
                send_data(8'hED);
                send_data(8'($urandom_range(8'hA0, 8'hBF)));
                send_data(8'($urandom_range(8'h80, 8'hBF)));
            end
            default: begin                                       // above U+10FFFF
                send_data(8'hF4);
                send_data(8'($urandom_range(8'h90, 8'hBF)));
                send_data(8'($urandom_range(8'h80, 8'hBF)));
                send_data(8'($urandom_range(8'h80, 8'hBF)));
            end
        endcase
    endtask

    // Any kind, any byte: mostly ignored after a string has ended
    task automatic send_noise(int n);
        repeat (n)
            send_json_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_string();
        int roll;
        send_begin();
        repeat ($urandom_range(0, 7))
            send_random_token();
        roll = $urandom_range(0, 99);
        if (roll < 55)
            send_data(CH_QUOTE);
        else if (roll < 63)
            send_end();
        else
            send_broken_tail($urandom_range(0, 17));
        if ($urandom_range(0, 3) == 0)
            send_noise($urandom_range(1, 4));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Before any begin, data, end and the undefined kind give nothing
    task automatic test_ignored_when_idle();
        send_data(8'h41);
        send_end();
        send_json_item(KIND_UNUSED, 8'hFF);
    endtask

    // Byte extremes, \u0000, the highest surrogate pair, undefined kind mid-string
    task automatic test_decode_extremes();
        send_begin();
        send_data(8'h20);
        send_data(8'h7F);
        send_json_item(KIND_UNUSED, 8'h00);
        send_text("\\u0000");
        send_text("\\uDBFF\\udfff");
        send_data(CH_QUOTE);
        send_data(8'h41);   // after the closing quote: ignored
    endtask

    task automatic test_error_reporting();
        send_begin();
        send_end();                                 // unterminated string
        send_begin();
        send_data(8'h1F);                           // control byte
        send_begin();
        send_text("\\uD83D");
        send_end();                                 // high half then end
        send_begin();
        send_data(8'hE0);
        send_data(8'h80);
        send_data(8'h80);                           // overlong three-byte form
        send_data(CH_QUOTE);                        // ignored after the error
    endtask

    task automatic test_random_traffic(int live_goal);
        int stop_at;
        stop_at = live_items + live_goal;
        while (live_items < stop_at)
            send_random_string();
    endtask

    // A stretch with no idling on either side
    task automatic test_full_rate(int live_goal);
        tx_gaps = 1'b0;
        rx_steady = 1'b1;
        test_random_traffic(live_goal);
        tx_gaps = 1'b1;
        rx_steady = 1'b0;
    endtask

    // Receiver holds off while the sender keeps offering: input must stall
    task automatic test_result_backpressure();
        tx_gaps = 1'b0;
        rx_hold_req = 300;
        test_random_traffic(40);
        tx_gaps = 1'b1;
    endtask

    // Sender stops until every result is out, then goes on
    task automatic test_pause_until_drained();
        test_random_traffic(20);
        wait_all_decoded();
        test_random_traffic(20);
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ignored_when_idle();
        test_decode_extremes();
        test_error_reporting();
        test_random_traffic(100);
        test_full_rate(60);
        test_result_backpressure();
        test_pause_until_drained();

        // all stimulus accepted: let the tail drain, then a short settle window
        wait_all_decoded();
        repeat (SettleCycles) @(posedge clk);
        if (fail_count == 0)
            $display("json_string_unescape_utf8 regression: pass");
        else
            $display("json_string_unescape_utf8 regression: fail");
        $finish;
    end

endmodule
